// File: hdl/dwlr_pkg.sv
// Shared types and constants for the lazy-reverse deque.
`default_nettype none
package dwlr_pkg;

	localparam int DATA_W          = 16;  // element / value field width
	localparam int CMD_W           = 2;
	localparam int STAT_W          = 2;
	localparam int DEPTH_DEF       = 64;
	localparam int VALUE_BITS_DEF  = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD    = 2'd0,
		CMD_REVERSE = 2'd1,
		CMD_DELETE  = 2'd2,
		CMD_FINISH  = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_ELEMENT  = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_ERROR    = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

endpackage : dwlr_pkg
`default_nettype wire

// File: hdl/dwlr_ram.sv
// Element store: one write port, one registered read port with enable.
`default_nettype none
module dwlr_ram #(
	parameter int DEPTH  = dwlr_pkg::DEPTH_DEF,
	parameter int WIDTH  = dwlr_pkg::DATA_W,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);
	import dwlr_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule : dwlr_ram
`default_nettype wire

// File: hdl/deque_with_lazy_reverse.sv
// Top level: bounded deque with lazy reversal, stream in / stream out.
// Load, reverse, delete: a new command is taken every cycle while idle (not draining a finish).
// Finish: the command moves the state to drain; each result is then registered in the output stage;
//   elements stream one per cycle (RAM read port) while the receiver is ready; the input stays
//   stalled until the last element or the status item has been loaded into the output stage.
// Reset (arst_n low, async) clears state, head, count and flags; the drain pointer and the store are not cleared.
`default_nettype none
module deque_with_lazy_reverse #(
	parameter int DEPTH      = dwlr_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = dwlr_pkg::VALUE_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// command transactions
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [dwlr_pkg::DATA_W-1:0] s_axis_tdata,  // [15:0] value
	input  wire logic [dwlr_pkg::CMD_W-1:0]  s_axis_tuser,  // [1:0] command
	// result transactions
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic      [dwlr_pkg::DATA_W-1:0] m_axis_tdata,  // [15:0] element
	output logic      [dwlr_pkg::STAT_W-1:0] m_axis_tuser,  // [1:0] status
	output logic                             m_axis_tlast
);
	import dwlr_pkg::*;

	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int STORE_W = (VALUE_BITS < DATA_W) ? VALUE_BITS : DATA_W;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,   // taking commands
		S_EMIT = 2'b10    // draining a finish
	} state_t;

	// modular index helpers; sums stay below 2*DEPTH
	function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W:0] s);
		if (s >= (IDX_W+1)'(DEPTH)) begin
			return IDX_W'(s - (IDX_W+1)'(DEPTH));
		end
		return s[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
	endfunction

	state_t             state_q;
	logic [IDX_W-1:0]   head_q;
	logic [CNT_W-1:0]   count_q;
	logic               rev_q;
	logic               err_q;
	logic               ovf_q;

	// finish drain context
	status_t            em_kind_q;
	logic [CNT_W-1:0]   em_rem_q;
	logic [IDX_W-1:0]   em_ptr_q;
	logic               em_rev_q;

	// output stage (element data sits in the RAM read register)
	logic               out_valid_q;
	status_t            out_stat_q;
	logic               out_last_q;
	logic               out_zero_q;

	cmd_t               cmd;
	logic               in_acc;
	logic               full;
	logic               ram_we;
	logic [IDX_W-1:0]   tail_idx;
	logic [IDX_W-1:0]   back_idx;
	logic               fire;
	logic               ram_re;
	logic [STORE_W-1:0] ram_rdata;
	status_t            fin_kind;

	assign cmd           = cmd_t'(s_axis_tuser);
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign full          = (count_q == CNT_W'(DEPTH));

	assign tail_idx = wrap_idx((IDX_W+1)'(head_q) + (IDX_W+1)'(count_q));
	assign back_idx = wrap_idx((IDX_W+1)'(head_q) + (IDX_W+1)'(count_q) - 1'b1);

	// load writes at the physical tail regardless of orientation
	assign ram_we = in_acc && (cmd == CMD_LOAD) && !err_q && !full;

	// emit when the output slot is empty or being drained
	assign fire   = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready);
	assign ram_re = fire && (em_kind_q == ST_ELEMENT);

	// finish priority: error, overflow, empty, elements
	always_comb begin
		if (err_q) begin
			fin_kind = ST_ERROR;
		end else if (ovf_q) begin
			fin_kind = ST_OVERFLOW;
		end else if (count_q == '0) begin
			fin_kind = ST_EMPTY;
		end else begin
			fin_kind = ST_ELEMENT;
		end
	end

	dwlr_ram #(
		.DEPTH (DEPTH),
		.WIDTH (STORE_W),
		.ADDR_W(IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tail_idx),
		.wdata(s_axis_tdata[STORE_W-1:0]),
		.re   (ram_re),
		.raddr(em_ptr_q),
		.rdata(ram_rdata)
	);

	// command processing and drain control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			rev_q     <= 1'b0;
			err_q     <= 1'b0;
			ovf_q     <= 1'b0;
			em_kind_q <= ST_EMPTY;
			em_rem_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (cmd)
							CMD_LOAD: begin
								if (!err_q) begin
									if (full) begin
										ovf_q <= 1'b1;   // value dropped
									end else begin
										count_q <= count_q + 1'b1;
									end
								end
							end
							CMD_REVERSE: begin
								if (!err_q) begin
									rev_q <= ~rev_q;
								end
							end
							CMD_DELETE: begin
								if (!err_q) begin
									if (count_q == '0) begin
										err_q <= 1'b1;   // sticky
									end else begin
										if (!rev_q) begin
											head_q <= idx_inc(head_q);
										end
										count_q <= count_q - 1'b1;
									end
								end
							end
							CMD_FINISH: begin
								em_kind_q <= fin_kind;
								em_rem_q  <= count_q;
								state_q   <= S_EMIT;
								// head, count and flags return to reset value
								head_q    <= '0;
								count_q   <= '0;
								rev_q     <= 1'b0;
								err_q     <= 1'b0;
								ovf_q     <= 1'b0;
							end
						endcase
					end
				end
				S_EMIT: begin
					if (fire) begin
						if (em_kind_q != ST_ELEMENT || em_rem_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end
						if (em_kind_q == ST_ELEMENT) begin
							em_rem_q <= em_rem_q - 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// drain read pointer (payload, no reset)
	always_ff @(posedge clk) begin
		if (in_acc && cmd == CMD_FINISH) begin
			em_ptr_q <= rev_q ? back_idx : head_q;
			em_rev_q <= rev_q;
		end else if (ram_re) begin
			em_ptr_q <= em_rev_q ? idx_dec(em_ptr_q) : idx_inc(em_ptr_q);
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output sideband, loaded alongside the RAM read
	always_ff @(posedge clk) begin
		if (fire) begin
			out_stat_q <= em_kind_q;
			out_zero_q <= (em_kind_q != ST_ELEMENT);
			out_last_q <= (em_kind_q != ST_ELEMENT) || (em_rem_q == CNT_W'(1));
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_zero_q ? '0 : DATA_W'(ram_rdata);
	assign m_axis_tuser  = out_stat_q;
	assign m_axis_tlast  = out_last_q;

	// ---- checks ----
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("element count above depth");

	a_finish_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && cmd == CMD_FINISH) |=> !s_axis_tready)
		else $error("input not stalled after finish");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != ST_ELEMENT) |-> (m_axis_tlast && m_axis_tdata == '0))
		else $error("status item must be last with zero element");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && em_kind_q == ST_ELEMENT) |-> (em_rem_q != '0))
		else $error("element drain with nothing left");

endmodule : deque_with_lazy_reverse
`default_nettype wire

// File: dv/deque_with_lazy_reverse_tb.sv
// Self-checking stream testbench for the lazy-reverse deque: directed plus random commands.
`default_nettype none
module deque_with_lazy_reverse_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dwlr_pkg::*;

	localparam int STORE_DEPTH  = DEPTH_DEF;
	localparam int RANDOM_ITEMS = 220;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int HOLD_CYCLES  = 200;   // long receiver hold-off to back up the finish burst
	localparam int CALM_TAIL    = 40;    // last commands run with no idling on either side

	// one command transaction as queued for the driver
	typedef struct {
		cmd_t        command;
		logic [15:0] value;
		bit          hold;    // start the long receiver hold when this one goes out
	} cmd_item_t;

	// one result transaction, as predicted or as observed
	typedef struct packed {
		logic [15:0] element;
		status_t     status;
		logic        last;
	} result_t;

	result_t expected_results[$];

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;    // [15:0] value
	logic [1:0]  s_axis_tuser = '0;    // [1:0] command
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;         // [15:0] element
	logic [1:0]  m_axis_tuser;         // [1:0] status
	logic        m_axis_tlast;

	deque_with_lazy_reverse u_top (
		.clk,
		.arst_n,
		.s_axis_tvalid,
		.s_axis_tready,
		.s_axis_tdata,
		.s_axis_tuser,
		.m_axis_tvalid,
		.m_axis_tready,
		.m_axis_tdata,
		.m_axis_tuser,
		.m_axis_tlast
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// free-running cycle count; also the watchdog
	int cyc = 0;
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still outstanding", cyc,
				expected_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Command generation. The generator keeps a rough count of its own so
	// that most sequences stay well formed (no delete on an empty deque).
	// ------------------------------------------------------------------
	cmd_item_t pending_cmds[$];
	int        gen_count = 0;
	bit        gen_err = 1'b0;
	bit        counting = 1'b0;
	int        random_items = 0;

	task automatic add_command(cmd_t c, logic [15:0] v, bit hold);
		cmd_item_t item;
		// commands swallowed by a sticky error do not count toward the random total
		if (counting && (c == CMD_FINISH || !gen_err))
			random_items++;
		case (c)
			CMD_LOAD: if (!gen_err && gen_count < STORE_DEPTH) gen_count++;
			CMD_DELETE: if (!gen_err) begin
				if (gen_count == 0)
					gen_err = 1'b1;
				else
					gen_count--;
			end
			CMD_FINISH: begin
				gen_count = 0;
				gen_err   = 1'b0;
			end
			default: ;
		endcase
		item = '{command: c, value: v, hold: hold};
		pending_cmds = {pending_cmds, item};
	endtask

	// mostly random values, with the all-zero and all-one extremes mixed in
	function automatic logic [15:0] rand_value();
		case ($urandom_range(0, 7))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Driver: one transaction in flight, random idle bursts in alternating
	// windows (while cyc[6] is high), none near the end.
	// ------------------------------------------------------------------
	cmd_item_t cur_cmd;
	int        send_gap = 0;
	bit        tail_calm = 1'b0;
	bit        hold_go = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (send_gap > 0) begin
				send_gap      <= send_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_cmds.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (!tail_calm && cyc[6] && $urandom_range(0, 5) == 0) begin
				send_gap      <= $urandom_range(0, 5);
				s_axis_tvalid <= 1'b0;
			end else begin
				cur_cmd = pending_cmds[0];
				pending_cmds.delete(0);
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= cur_cmd.value;
				s_axis_tuser  <= cur_cmd.command;
				if (cur_cmd.hold)
					hold_go <= 1'b1;
			end
		end
		tail_calm <= (pending_cmds.size() <= CALM_TAIL);
	end

	// ------------------------------------------------------------------
	// Long hold-off: counted here, once, right after the big finish goes
	// out. The 64-element burst backs up and the block stalls its input
	// while the driver keeps offering the next commands.
	// ------------------------------------------------------------------
	int hold_left = 0;
	bit hold_used = 1'b0;

	always @(posedge clk) begin
		if (hold_go && !hold_used) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver ready: long hold, then random stall bursts in other windows
	int recv_gap = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0 || (hold_go && !hold_used)) begin
			m_axis_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap      <= recv_gap - 1;
			m_axis_tready <= 1'b0;
		end else if (!tail_calm && cyc[7] && $urandom_range(0, 4) == 0) begin
			recv_gap      <= $urandom_range(0, 5);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Predictor: own copy of the deque. Store is circular, head + count
	// addressed; reverse only flips the orientation bit.
	// ------------------------------------------------------------------
	logic [15:0] q_store [STORE_DEPTH];
	logic [5:0]  q_head = '0;
	logic [6:0]  q_count = '0;
	logic        q_rev = 1'b0;
	logic        q_err = 1'b0;
	logic        q_ovf = 1'b0;

	int      cmd_seen[4] = '{default: 0};
	int      status_seen[4] = '{default: 0};
	int      results_checked = 0;
	int      mismatch_count = 0;

	task automatic add_expected(logic [15:0] e, status_t s, logic l);
		result_t r;
		r = '{element: e, status: s, last: l};
		expected_results = {expected_results, r};
	endtask

	task automatic predict_command(cmd_t c, logic [15:0] v);
		int p;
		cmd_seen[c]++;
		case (c)
			CMD_LOAD: if (!q_err) begin
				if (q_count == 7'(STORE_DEPTH)) begin
					q_ovf = 1'b1;    // full: value dropped
				end else begin
					q_store[6'(q_head + q_count)] = v;
					q_count++;
				end
			end
			CMD_REVERSE: if (!q_err) q_rev = !q_rev;
			CMD_DELETE: if (!q_err) begin
				if (q_count == 0) begin
					q_err = 1'b1;    // underflow sticks until finish
				end else begin
					// reversed: the back goes, head stays
					if (!q_rev)
						q_head++;
					q_count--;
				end
			end
			CMD_FINISH: begin
				// error beats overflow beats empty
				if (q_err)
					add_expected(16'h0000, ST_ERROR, 1'b1);
				else if (q_ovf)
					add_expected(16'h0000, ST_OVERFLOW, 1'b1);
				else if (q_count == 0)
					add_expected(16'h0000, ST_EMPTY, 1'b1);
				else
					for (int i = 0; i < q_count; i++) begin
						p = q_rev ? (q_head + q_count - 1 - i) : (q_head + i);
						add_expected(q_store[p % STORE_DEPTH], ST_ELEMENT,
							(i == q_count - 1));
					end
				q_head  = '0;
				q_count = '0;
				q_rev   = 1'b0;
				q_err   = 1'b0;
				q_ovf   = 1'b0;
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(string what, result_t want, result_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("MISMATCH (%s) at result %0d:", what, results_checked);
			$display("  expected element=%h status=%0d last=%b",
				want.element, want.status, want.last);
			$display("  actual   element=%h status=%0d last=%b",
				got.element, got.status, got.last);
		end
	endtask

	task automatic check_result(result_t got);
		result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("nothing expected", '0, got);
		end else begin
			want = expected_results[0];
			expected_results.delete(0);
			if (got.element !== want.element || got.status !== want.status ||
				got.last !== want.last)
				report_mismatch("field", want, got);
		end
		status_seen[got.status]++;
		results_checked++;
	endtask

	// monitor: predict on accepted commands, compare on accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				predict_command(cmd_t'(s_axis_tuser), s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				check_result('{element: m_axis_tdata, status: status_t'(m_axis_tuser),
					last: m_axis_tlast});
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int n;
		int len;
		int kind;
		int r;

		// directed: finish on an empty deque
		add_command(CMD_FINISH, 16'h0000, 1'b0);
		// field extremes, then a reversed dump
		add_command(CMD_LOAD, 16'h0000, 1'b0);
		add_command(CMD_LOAD, 16'hFFFF, 1'b0);
		add_command(CMD_LOAD, 16'h5555, 1'b0);
		add_command(CMD_LOAD, 16'hAAAA, 1'b0);
		add_command(CMD_REVERSE, 16'hFFFF, 1'b0);
		add_command(CMD_FINISH, 16'hFFFF, 1'b0);
		// delete from the front, then from the back while reversed
		add_command(CMD_LOAD, 16'h0001, 1'b0);
		add_command(CMD_LOAD, 16'h0002, 1'b0);
		add_command(CMD_LOAD, 16'h0003, 1'b0);
		add_command(CMD_DELETE, 16'h0000, 1'b0);
		add_command(CMD_REVERSE, 16'h0000, 1'b0);
		add_command(CMD_DELETE, 16'h0000, 1'b0);
		add_command(CMD_LOAD, 16'h0004, 1'b0);
		add_command(CMD_FINISH, 16'h0000, 1'b0);
		// underflow: error sticks, later commands ignored
		add_command(CMD_DELETE, 16'h0000, 1'b0);
		add_command(CMD_LOAD, 16'h0007, 1'b0);
		add_command(CMD_REVERSE, 16'h0000, 1'b0);
		add_command(CMD_DELETE, 16'h0000, 1'b0);
		add_command(CMD_FINISH, 16'h0000, 1'b0);
		// emptied by delete after the head moved
		add_command(CMD_LOAD, 16'h0009, 1'b0);
		add_command(CMD_DELETE, 16'h0000, 1'b0);
		add_command(CMD_FINISH, 16'h0000, 1'b0);

		counting = 1'b1;

		// full deque with the head moved so the store wraps; 64-element
		// finish with the long receiver hold
		n = $urandom_range(3, 10);
		repeat (n) add_command(CMD_LOAD, rand_value(), 1'b0);
		repeat (n) add_command(CMD_DELETE, 16'($urandom), 1'b0);
		repeat (STORE_DEPTH) add_command(CMD_LOAD, rand_value(), 1'b0);
		add_command(CMD_FINISH, 16'($urandom), 1'b1);

		// overflow: loads past a full deque
		repeat (STORE_DEPTH + $urandom_range(1, 3)) add_command(CMD_LOAD, rand_value(), 1'b0);
		add_command(CMD_REVERSE, 16'($urandom), 1'b0);
		add_command(CMD_FINISH, 16'($urandom), 1'b0);

		while (random_items < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			if (kind < 8) begin
				// well formed: loads, reverses, deletes that never underflow
				len = $urandom_range(1, 24);
				repeat (len) begin
					r = $urandom_range(0, 99);
					if (r < 55 || (r >= 75 && gen_count == 0))
						add_command(CMD_LOAD, rand_value(), 1'b0);
					else if (r < 75)
						add_command(CMD_REVERSE, 16'($urandom), 1'b0);
					else
						add_command(CMD_DELETE, 16'($urandom), 1'b0);
				end
				add_command(CMD_FINISH, 16'($urandom), 1'b0);
			end else if (kind == 8) begin
				// broken: one delete too many, then commands the error swallows
				repeat ($urandom_range(0, 3)) add_command(CMD_LOAD, rand_value(), 1'b0);
				repeat (gen_count + 1) add_command(CMD_DELETE, 16'($urandom), 1'b0);
				repeat ($urandom_range(1, 4))
					add_command(cmd_t'($urandom_range(0, 2)), 16'($urandom), 1'b0);
				add_command(CMD_FINISH, 16'($urandom), 1'b0);
			end else begin
				// noise: any command, any value
				repeat ($urandom_range(1, 8))
					add_command(cmd_t'($urandom_range(0, 3)), 16'($urandom), 1'b0);
			end
		end
		add_command(CMD_FINISH, 16'($urandom), 1'b0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// all commands accepted, then all results in, then a quiet margin;
		// checked mid-cycle so the driver's updates have settled
		while (pending_cmds.size() != 0 || s_axis_tvalid) @(negedge clk);
		while (expected_results.size() != 0) @(negedge clk);
		repeat (20) @(posedge clk);

		$display("Commands: %0d load, %0d reverse, %0d delete, %0d finish",
			cmd_seen[CMD_LOAD], cmd_seen[CMD_REVERSE], cmd_seen[CMD_DELETE],
			cmd_seen[CMD_FINISH]);
		$display("Results: %0d checked (%0d element, %0d empty, %0d error, %0d overflow)",
			results_checked, status_seen[ST_ELEMENT], status_seen[ST_EMPTY],
			status_seen[ST_ERROR], status_seen[ST_OVERFLOW]);
		$display("Mismatches: %0d", mismatch_count);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule : deque_with_lazy_reverse_tb
`default_nettype wire
